/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, skipped while rst is high.
`define PSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/psf_pkg.sv */
`default_nettype none

package psf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int NAME_SLOTS_DEF = 2;

  localparam int ID_W = 64;
  localparam int CNT_W = 32;
  localparam int NAME_W = 128;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int S_TDATA_W = 264;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 40;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CLS_OTHER  = 2'd0;
  localparam logic [1:0] CLS_CREATE = 2'd1;
  localparam logic [1:0] CLS_EXIT   = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_NAME_A_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NAME_A_HIGH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NAME_B_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NAME_B_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NAME_ENABLE = 3'd4;

  typedef enum logic [1:0] {
    ROUTE_NOW   = 2'd0,
    ROUTE_SCAN  = 2'd1,
    ROUTE_CLEAR = 2'd2
  } route_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic clear_wr;
    logic finish;
  } psf_cmd_t;

  typedef struct packed {
    route_t route;
    logic   addr_last;
    logic   out_free;
  } psf_stat_t;

  // Zero every byte from the first zero byte on.
  function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] n);
    logic ended;
    logic [NAME_W-1:0] r;
    ended = 1'b0;
    r = '0;
    for (int b = 0; b < NAME_W / 8; b++) begin
      if (n[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = n[b*8 +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/psf_ctrl.sv */
`default_nettype none

module psf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  psf_pkg::psf_stat_t stat,
  output psf_pkg::psf_cmd_t  cmd
);
  import psf_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.clear_wr = 1'b1;
        if (stat.addr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (stat.route)
            ROUTE_SCAN:  state_next = ST_SCAN;
            ROUTE_CLEAR: state_next = ST_CLEAR;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.addr_last) state_next = ST_DRAIN;
      end
      // The last entry read is compared in this cycle.
      ST_DRAIN: state_next = ST_FINISH;
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.addr_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/psf_datapath.sv */
`default_nettype none

module psf_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int NAME_SLOTS = 2
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [psf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [psf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [psf_pkg::S_TUSER_W-1:0]      s_tuser,
  input  wire  [psf_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [psf_pkg::M_TDATA_W-1:0]      m_tdata,
  input  psf_pkg::psf_cmd_t                  cmd,
  output psf_pkg::psf_stat_t                 stat
);
  import psf_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // Configured names.
  logic [ID_W-1:0]       name_lo [NAME_SLOTS];
  logic [ID_W-1:0]       name_hi [NAME_SLOTS];
  logic [NAME_SLOTS-1:0] name_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NAME_SLOTS; s++) begin
        name_lo[s] <= '0;
        name_hi[s] <= '0;
      end
      name_en <= '0;
    end else if (cfg_we) begin
      for (int s = 0; s < NAME_SLOTS; s++) begin
        if (cfg_addr == ((s == 0) ? CFG_NAME_A_LOW : CFG_NAME_B_LOW)) name_lo[s] <= cfg_data;
        if (cfg_addr == ((s == 0) ? CFG_NAME_A_HIGH : CFG_NAME_B_HIGH)) name_hi[s] <= cfg_data;
      end
      if (cfg_addr == CFG_NAME_ENABLE) name_en <= cfg_data[NAME_SLOTS-1:0];
    end
  end

  // Latched item.
  logic [1:0]      req_q, cls_q;
  logic [ID_W-1:0] tid_q, ptid_q, nlo_q, nhi_q;
  logic            pok_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= s_tuser[1:0];
      cls_q  <= s_tuser[3:2];
      tid_q  <= s_tdata[63:0];
      ptid_q <= s_tdata[127:64];
      nlo_q  <= s_tdata[191:128];
      nhi_q  <= s_tdata[255:192];
      pok_q  <= s_tdata[256];
    end
  end

  logic name_hit, name_hit_c;
  logic [NAME_W-1:0] ev_name_cut;
  assign ev_name_cut = cut_name({nhi_q, nlo_q});

  always_comb begin
    name_hit_c = 1'b0;
    for (int s = 0; s < NAME_SLOTS; s++) begin
      if (name_en[s] && cut_name({name_hi[s], name_lo[s]}) == ev_name_cut) name_hit_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    name_hit <= name_hit_c;
  end

  // Table address counter, shared by the scan and the clearing sweep.
  logic [IDX_W-1:0] addr;

  always_comb begin
    stat.addr_last = (addr == IDX_LAST);
    stat.out_free  = !m_tvalid || m_tready;
    case (s_tuser[1:0])
      REQ_ADD:   stat.route = ROUTE_SCAN;
      REQ_CLEAR: stat.route = ROUTE_CLEAR;
      REQ_EVENT: begin
        if (s_tuser[3:2] == CLS_CREATE && !s_tdata[256]) stat.route = ROUTE_NOW;
        else                                            stat.route = ROUTE_SCAN;
      end
      default:   stat.route = ROUTE_NOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) addr <= '0;
    else if (cmd.scan_rd || cmd.clear_wr) addr <= stat.addr_last ? '0 : addr + 1'b1;
  end

  // Table memory: valid bit on top of the id.
  logic [ID_W:0]    mem [TABLE_DEPTH];
  logic [ID_W:0]    rd_data;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W:0]    wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) rd_data <= mem[addr];
    rd_idx <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= cmd.scan_rd;
  end

  // Scan results.
  logic             tid_found, par_found, free_found;
  logic [IDX_W-1:0] tid_idx, free_idx;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      tid_found  <= 1'b0;
      par_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_valid) begin
      if (rd_data[ID_W] && rd_data[ID_W-1:0] == tid_q && !tid_found) begin
        tid_found <= 1'b1;
        tid_idx   <= rd_idx;
      end
      if (rd_data[ID_W] && rd_data[ID_W-1:0] == ptid_q) par_found <= 1'b1;
      if (!rd_data[ID_W] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  // Outcome of the item.
  logic is_create, is_exit, is_other, hit_create, need_ins, ins_ok, del_ok;
  logic filt, full;

  always_comb begin
    is_create  = (req_q == REQ_EVENT) && (cls_q == CLS_CREATE);
    is_exit    = (req_q == REQ_EVENT) && (cls_q == CLS_EXIT);
    is_other   = (req_q == REQ_EVENT) && !is_create && !is_exit;
    hit_create = is_create && pok_q && (((ptid_q != '0) && par_found) || name_hit);
    need_ins   = (req_q == REQ_ADD) || hit_create;
    ins_ok     = need_ins && !tid_found && free_found;
    full       = need_ins && !tid_found && !free_found;
    del_ok     = is_exit && tid_found;
    filt       = hit_create || (is_other && (tid_q != '0) && tid_found);
  end

  always_comb begin
    wr_en   = cmd.clear_wr || (cmd.finish && (ins_ok || del_ok));
    wr_addr = cmd.clear_wr ? addr : (ins_ok ? free_idx : tid_idx);
    wr_data = cmd.clear_wr ? '0 : {ins_ok, tid_q};
  end

  // Counter and result register.
  logic [CNT_W-1:0] counter, counter_next;
  assign counter_next = counter + CNT_W'(filt);

  always_ff @(posedge clk) begin
    if (rst) counter <= '0;
    else if (cmd.finish) counter <= counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {6'd0, full, counter_next, filt};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/process_suppression_filter.sv */
// Flow: an event or add request reads each entry through the single table read port, then
// passes a compare stage and a finish state that registers its result; a clear writes each
// entry instead. One item is taken at a time, and the next only after the finish state of
// the last, which waits for a free output register; an unused request code or a creating
// event with params_ok clear skips the table. Reset: synchronous; after it a sweep invalidates
// every table entry before the first item is taken. Config writes are taken at any time.
`default_nettype none

module process_suppression_filter #(
  parameter int TABLE_DEPTH = psf_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_SLOTS = psf_pkg::NAME_SLOTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [psf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [psf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // thread_id, parent_id, name_low, name_high, params_ok, zero pad
  input  wire  [psf_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type, event_class
  input  wire  [psf_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // filtered, filtered_count, table_full, zero pad
  output logic [psf_pkg::M_TDATA_W-1:0]   m_tdata
);
  import psf_pkg::*;

  psf_cmd_t  cmd;
  psf_stat_t stat;

  psf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psf_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_SLOTS  (NAME_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  logic             m_drop;
  logic [CNT_W-1:0] m_cnt;
  assign m_drop = m_tdata[0];
  assign m_cnt  = m_tdata[CNT_W:1];

`include "assert_macros.svh"

  `PSF_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second beat taken while busy")
  `PSF_ASSERT(a_cnt_step, !$stable(m_cnt) |-> m_drop && m_cnt == $past(m_cnt) + 1'b1, "stray count")
  `PSF_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "beats offered right after reset")

endmodule

`default_nettype wire

/* dv/process_suppression_filter_tb.sv */
module process_suppression_filter_tb;
  import psf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CLS_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [1:0]  cls;
    logic [63:0] tid;
    logic [63:0] ptid;
    logic [63:0] nlo;
    logic [63:0] nhi;
    logic        pok;
  } request_t;

  typedef struct packed {
    logic        filtered;
    logic [31:0] count;
    logic        full;
  } verdict_t;

  // Tracks the suppressed-id set, the drop counter and the name registers, and
  // queues the verdict that each accepted request should produce.
  class verdict_tracker;
    logic [63:0]  ids [TABLE_DEPTH_DEF];
    bit           live [TABLE_DEPTH_DEF];
    logic [31:0]  drops;
    logic [127:0] names [NAME_SLOTS_DEF];
    logic [1:0]   name_on;
    verdict_t     pending_verdicts [$];
    int           faults;
    int           checked;
    int           dropped_seen;
    int           overflow_seen;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      foreach (names[i]) names[i] = '0;
      drops = '0;
      name_on = '0;
      faults = 0;
      checked = 0;
      dropped_seen = 0;
      overflow_seen = 0;
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
      case (idx)
        CFG_NAME_A_LOW:  names[0][63:0] = val;
        CFG_NAME_A_HIGH: names[0][127:64] = val;
        CFG_NAME_B_LOW:  names[1][63:0] = val;
        CFG_NAME_B_HIGH: names[1][127:64] = val;
        CFG_NAME_ENABLE: name_on = val[1:0];
        default: ;
      endcase
    endfunction

    function int slot_of(logic [63:0] id);
      foreach (live[i]) if (live[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function bit held(logic [63:0] id);
      return id != '0 && slot_of(id) >= 0;
    endfunction

    // Returns 1 when the id had to be dropped because every entry is taken.
    function bit enter(logic [63:0] id);
      if (slot_of(id) >= 0) return 1'b0;
      foreach (live[i]) begin
        if (!live[i]) begin
          ids[i] = id;
          live[i] = 1'b1;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Everything from the first zero byte on reads as zero.
    function logic [127:0] trim(logic [127:0] n);
      logic [127:0] r;
      int stop;
      stop = 16;
      for (int b = 15; b >= 0; b--) if (n[b*8 +: 8] == 8'h00) stop = b;
      r = n;
      for (int b = 0; b < 16; b++) if (b >= stop) r[b*8 +: 8] = 8'h00;
      return r;
    endfunction

    function bit name_hit(logic [127:0] n);
      logic [127:0] t;
      t = trim(n);
      for (int s = 0; s < NAME_SLOTS_DEF; s++)
        if (name_on[s] && trim(names[s]) == t) return 1'b1;
      return 1'b0;
    endfunction

    function void take_request(request_t rq);
      verdict_t v;
      int slot;
      v = '0;
      case (rq.req)
        REQ_ADD: v.full = enter(rq.tid);
        REQ_CLEAR: foreach (live[i]) live[i] = 1'b0;
        REQ_EVENT: begin
          if (rq.cls == CLS_CREATE) begin
            if (rq.pok && (held(rq.ptid) || name_hit({rq.nhi, rq.nlo}))) begin
              v.full = enter(rq.tid);
              v.filtered = 1'b1;
            end
          end else if (rq.cls == CLS_EXIT) begin
            slot = slot_of(rq.tid);
            if (slot >= 0) live[slot] = 1'b0;
          end else begin
            v.filtered = held(rq.tid);
          end
          if (v.filtered) drops = drops + 32'd1;
        end
        default: ;
      endcase
      v.count = drops;
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function void check_verdict(logic [M_TDATA_W-1:0] d);
      verdict_t got;
      verdict_t want;
      got.filtered = d[0];
      got.count = d[32:1];
      got.full = d[33];
      if (pending_verdicts.size() == 0) begin
        report($sformatf("verdict with nothing pending: filtered %0d count %0d table_full %0d",
                         got.filtered, got.count, got.full));
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (want.filtered) dropped_seen++;
      if (want.full) overflow_seen++;
      if (got !== want)
        report($sformatf({"filtered exp %0d got %0d, filtered_count exp %0d got %0d, ",
                          "table_full exp %0d got %0d"}, want.filtered, got.filtered,
                         want.count, got.count, want.full, got.full));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  verdict_tracker sb = new();
  bit idle_on = 1'b1;
  int sent = 0;
  logic [63:0] id_pool [8];
  logic [127:0] name_a;
  logic [127:0] name_b;

  process_suppression_filter u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_verdict(m_tdata);
  end

  initial begin
    #5_000_000;
    $display("FAIL process_suppression_filter");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_id();
    if ($urandom_range(5) == 0) return rand64();
    return id_pool[3'($urandom_range(7))];
  endfunction

  // Fills every byte after the first zero byte with junk.
  function automatic logic [127:0] dirty(input logic [127:0] n);
    logic [127:0] r;
    bit hit;
    r = n;
    hit = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (hit) r[b*8 +: 8] = 8'($urandom_range(255));
      else if (n[b*8 +: 8] == 8'h00) hit = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [127:0] rand_name();
    logic [127:0] r;
    int len;
    r = '0;
    len = $urandom_range(16);
    for (int b = 0; b < len; b++) r[b*8 +: 8] = 8'($urandom_range(1, 255));
    if ($urandom_range(1)) r = dirty(r);
    return r;
  endfunction

  function automatic logic [127:0] event_name();
    case ($urandom_range(4))
      0: return dirty(name_a);
      1: return dirty(name_b);
      2: return '0;
      3: return rand_name();
      default: return {rand64(), rand64()};
    endcase
  endfunction

  function automatic request_t mk(logic [1:0] req, logic [1:0] cls, logic [63:0] tid,
                                  logic [63:0] ptid, logic [127:0] nm, logic pok);
    request_t r;
    r.req = req;
    r.cls = cls;
    r.tid = tid;
    r.ptid = ptid;
    r.nlo = nm[63:0];
    r.nhi = nm[127:64];
    r.pok = pok;
    return r;
  endfunction

  // Entered just after a falling edge; returns just after the falling edge
  // that follows acceptance, with the beat still presented.
  task automatic send(input request_t rq);
    while (idle_on && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {rq.cls, rq.req};
    s_tdata <= {7'd0, rq.pok, rq.nhi, rq.nlo, rq.ptid, rq.tid};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.take_request(rq);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [127:0] a, input logic [127:0] b,
                              input logic [1:0] en);
    logic [CFG_ADDR_W-1:0] idx [5];
    logic [63:0] val [5];
    idx = '{CFG_NAME_A_LOW, CFG_NAME_A_HIGH, CFG_NAME_B_LOW, CFG_NAME_B_HIGH,
            CFG_NAME_ENABLE};
    val = '{a[63:0], a[127:64], b[63:0], b[127:64], {62'd0, en}};
    drain();
    name_a = a;
    name_b = b;
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A root, added outright or created by a random parent, then a chain of children, each
  // created by the previous one, touched by an ordinary event and sometimes exiting.
  task automatic lineage();
    logic [63:0] prev;
    logic [63:0] child;
    int steps;
    prev = pick_id();
    if ($urandom_range(1))
      send(mk(REQ_ADD, 2'($urandom_range(3)), prev, rand64(), event_name(),
              1'($urandom_range(1))));
    else
      send(mk(REQ_EVENT, CLS_CREATE, prev, pick_id(), event_name(), 1'b1));
    steps = $urandom_range(2, 6);
    repeat (steps) begin
      child = pick_id();
      send(mk(REQ_EVENT, CLS_CREATE, child, prev, event_name(), $urandom_range(9) != 0));
      send(mk(REQ_EVENT, CLS_OTHER, child, rand64(), event_name(), 1'($urandom_range(1))));
      if ($urandom_range(2) == 0)
        send(mk(REQ_EVENT, CLS_EXIT, child, rand64(), event_name(), 1'($urandom_range(1))));
      prev = child;
    end
  endtask

  task automatic noise();
    send(mk(2'($urandom_range(3)), 2'($urandom_range(3)),
            $urandom_range(1) ? pick_id() : rand64(),
            $urandom_range(1) ? pick_id() : rand64(), event_name(),
            1'($urandom_range(1))));
  endtask

  // Overfills the table, then checks that a suppressed parent still drops
  // its child while the insert is lost.
  task automatic fill_table();
    logic [63:0] root;
    root = rand64();
    send(mk(REQ_CLEAR, CLS_OTHER, rand64(), rand64(), rand_name(), 1'b0));
    send(mk(REQ_ADD, CLS_OTHER, root, rand64(), rand_name(), 1'b0));
    repeat (TABLE_DEPTH_DEF + 1)
      send(mk(REQ_ADD, 2'($urandom_range(3)), rand64(), rand64(), rand_name(),
              1'($urandom_range(1))));
    send(mk(REQ_EVENT, CLS_CREATE, rand64(), root, rand_name(), 1'b1));
    send(mk(REQ_EVENT, CLS_OTHER, root, rand64(), rand_name(), 1'b0));
    send(mk(REQ_EVENT, CLS_EXIT, root, rand64(), rand_name(), 1'b0));
    send(mk(REQ_ADD, CLS_OTHER, rand64(), rand64(), rand_name(), 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, root, rand64(), rand_name(), 1'b1));
    send(mk(REQ_CLEAR, CLS_OTHER, rand64(), rand64(), rand_name(), 1'b1));
  endtask

  initial begin
    int quota_start;
    bit paused;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = 64'd1;
    for (int i = 3; i < 8; i++) id_pool[i] = rand64();
    paused = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Name A is "bash" with junk after its terminator; name B has no zero byte.
    apply_config({64'h6b, 64'h6e756a00_68736162}, '1, 2'b11);
    send(mk(REQ_EVENT, CLS_OTHER, 64'd0, 64'd0, '0, 1'b0));
    send(mk(REQ_ADD, CLS_OTHER, 64'd5, 64'd0, '0, 1'b0));
    send(mk(REQ_ADD, CLS_OTHER, 64'd5, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd5, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_UNUSED, 64'd5, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_CREATE, 64'd7, 64'd5, 128'h736c, 1'b1));
    send(mk(REQ_EVENT, CLS_CREATE, 64'd8, 64'd5, 128'h736c, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd7, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_EXIT, 64'd7, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd7, 64'd0, '0, 1'b0));
    send(mk(REQ_ADD, CLS_OTHER, 64'd0, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd0, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_CREATE, 64'd11, 64'd0, 128'h736c, 1'b1));
    send(mk(REQ_EVENT, CLS_EXIT, 64'd0, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_CREATE, '1, '1, {64'h11, 64'h00797800_68736162}, 1'b1));
    send(mk(REQ_EVENT, CLS_CREATE, 64'd12, 64'd99, '1, 1'b1));
    send(mk(REQ_EVENT, CLS_CREATE, 64'd13, 64'd99, '0, 1'b1));
    send(mk(REQ_UNUSED, CLS_OTHER, 64'd5, 64'd5, '0, 1'b1));
    send(mk(REQ_EVENT, CLS_OTHER, '1, 64'd0, '0, 1'b0));
    send(mk(REQ_CLEAR, CLS_OTHER, 64'd0, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd5, 64'd0, '0, 1'b0));
    send(mk(REQ_EVENT, CLS_OTHER, '1, '1, '1, 1'b1));
    send(mk(REQ_EVENT, CLS_OTHER, 64'd0, 64'd0, '0, 1'b0));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_config(rand_name(), rand_name(), 2'b11);
        1: apply_config('0, '1, 2'b01);
        2: apply_config(rand_name(), '0, 2'b10);
        3: apply_config(rand_name(), rand_name(), 2'b00);
        4: apply_config('1, rand_name(), 2'b11);
        default: apply_config(rand_name(), rand_name(), 2'b01);
      endcase
      // One whole phase runs with both sides streaming back to back.
      idle_on = (p != 3);
      quota_start = sent;
      while (sent - quota_start < 75) begin
        if ($urandom_range(9) < 7) lineage();
        else noise();
        if (p == 2 && !paused && sent - quota_start > 40) begin
          drain();
          paused = 1'b1;
        end
      end
      if (p == 1 || p == 4) fill_table();
    end

    drain();
    repeat (TABLE_DEPTH_DEF + 3) @(posedge clk);
    if (sb.pending_verdicts.size() != 0)
      sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));
    $display("Sent %0d requests across seven name settings; %0d verdicts checked.",
             sent, sb.checked);
    $display("Of those, %0d events were dropped and %0d inserts were lost to a full table.",
             sb.dropped_seen, sb.overflow_seen);
    if (sb.faults == 0) begin
      $display("PASS process_suppression_filter");
    end else begin
      $display("%0d mismatches in total", sb.faults);
      $display("FAIL process_suppression_filter");
    end
    $finish;
  end

endmodule
